>>> rtl/sliding_median_filter_defines.svh
// assertion macros for the sliding median filter checker
`ifndef SLIDING_MEDIAN_FILTER_DEFINES_SVH
`define SLIDING_MEDIAN_FILTER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define SMF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define SMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/smf_pkg.sv
// shared types, constants and helpers of the sliding median filter
package smf_pkg;

  localparam int MAX_WINDOW  = 7;
  localparam int SAMPLE_BITS = 24;
  localparam int WS_BITS     = 3;
  localparam int MIN_FILTER  = 3;
  localparam int SEEN_LIMIT  = 7;
  localparam int SEEN_BITS   = $clog2(SEEN_LIMIT + 1);
  localparam int MAX_LAG     = MAX_WINDOW - 1 - MAX_WINDOW / 2;
  localparam int LAG_BITS    = $clog2(MAX_LAG + 1);
  localparam int CNT_BITS    = $clog2(SEEN_LIMIT + MAX_LAG + 1);
  localparam int RANK_BITS   = $clog2(MAX_WINDOW);

  localparam logic [WS_BITS-1:0] WS_RESET = WS_BITS'(5);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [MAX_WINDOW-1:0]      win_t;
  typedef logic [WS_BITS-1:0]            wsize_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          end_of_block;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          last_out;
  } out_t;

  // status of the window stage towards the result register
  typedef struct packed {
    logic   valid;
    logic   emit;
    logic   last;
    logic   pass;
    wsize_t w;
  } stat_t;

  function automatic wsize_t clamp_w(wsize_t w);
    wsize_t wc;
    wc = w;
    if (int'(w) > MAX_WINDOW) begin
      wc = WS_BITS'(MAX_WINDOW);
    end
    return wc;
  endfunction

  // output lag of a window: w - 1 - w/2
  function automatic logic [LAG_BITS-1:0] lag_of(wsize_t w);
    wsize_t d;
    d = w - WS_BITS'(1) - (w >> 1);
    return LAG_BITS'(d);
  endfunction

endpackage

>>> rtl/smf_median.sv
// rank-select median of the first w window entries
module smf_median (
  input  smf_pkg::win_t    win_i,
  input  smf_pkg::wsize_t  w_i,
  output smf_pkg::sample_t med_o
);
  import smf_pkg::*;

  logic [RANK_BITS-1:0]  rank [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] hit;
  sample_t               med;

  // ties broken by position so every rank below w is taken exactly once
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MAX_WINDOW; j++) begin
        if (j != i && j < int'(w_i) &&
            ($signed(win_i[j]) < $signed(win_i[i]) ||
             ($signed(win_i[j]) == $signed(win_i[i]) && j < i))) begin
          rank[i] = rank[i] + RANK_BITS'(1);
        end
      end
      hit[i] = (i < int'(w_i)) && (rank[i] == RANK_BITS'(w_i >> 1));
    end
  end

  always_comb begin
    med = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      med = med | (win_i[i] & {SAMPLE_BITS{hit[i]}});
    end
  end

  assign med_o = med;

endmodule

>>> rtl/smf_seq.sv
// sample window, block counter and end-of-block flush sequencer
module smf_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  smf_pkg::in_t    in_i,
  input  smf_pkg::wsize_t wsize_i,
  input  logic            adv_i,
  output smf_pkg::win_t   win_o,
  output smf_pkg::stat_t  stat_o
);
  import smf_pkg::*;

  win_t                 win_q, win_d;
  logic [SEEN_BITS-1:0] seen_q, seen_d;
  logic [LAG_BITS-1:0]  left_q, left_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  stat_t                stat_q, stat_d;

  logic                 accept;
  wsize_t               w_new;
  logic [LAG_BITS-1:0]  lag_new;
  logic [LAG_BITS-1:0]  lag_cur;
  logic [CNT_BITS-1:0]  cnt_inc;

  assign in_ready_o = !stat_q.valid || (adv_i && left_q == '0);
  assign accept     = in_valid_i && in_ready_o;
  assign w_new      = clamp_w(wsize_i);
  assign lag_new    = lag_of(w_new);
  assign lag_cur    = lag_of(stat_q.w);
  assign cnt_inc    = cnt_q + CNT_BITS'(1);

  always_comb begin
    win_d  = win_q;
    seen_d = seen_q;
    left_d = left_q;
    cnt_d  = cnt_q;
    stat_d = stat_q;
    if (adv_i && left_q != '0) begin
      // flush: repeat the newest sample past the end of the block
      win_d[0] = win_q[0];
      for (int i = 1; i < MAX_WINDOW; i++) begin
        win_d[i] = win_q[i-1];
      end
      left_d      = left_q - LAG_BITS'(1);
      cnt_d       = cnt_inc;
      stat_d.emit = cnt_inc >= CNT_BITS'(lag_cur);
      stat_d.last = left_q == LAG_BITS'(1);
    end else if (accept) begin
      win_d[0] = in_i.sample_in;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        // first sample of a block replicates to the left
        win_d[i] = (seen_q == '0) ? in_i.sample_in : win_q[i-1];
      end
      if (in_i.end_of_block) begin
        seen_d = '0;
      end else if (seen_q == SEEN_BITS'(SEEN_LIMIT)) begin
        seen_d = seen_q;
      end else begin
        seen_d = seen_q + SEEN_BITS'(1);
      end
      stat_d.valid = 1'b1;
      stat_d.w     = w_new;
      stat_d.pass  = int'(w_new) < MIN_FILTER;
      cnt_d        = CNT_BITS'(seen_q);
      if (int'(w_new) < MIN_FILTER) begin
        stat_d.emit = 1'b1;
        stat_d.last = in_i.end_of_block;
        left_d      = '0;
      end else begin
        stat_d.emit = CNT_BITS'(seen_q) >= CNT_BITS'(lag_new);
        stat_d.last = 1'b0;
        left_d      = in_i.end_of_block ? lag_new : '0;
      end
    end else if (adv_i) begin
      stat_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      seen_q <= '0;
      left_q <= '0;
      cnt_q  <= '0;
      stat_q <= '0;
    end else begin
      win_q  <= win_d;
      seen_q <= seen_d;
      left_q <= left_d;
      cnt_q  <= cnt_d;
      stat_q <= stat_d;
    end
  end

  assign win_o  = win_q;
  assign stat_o = stat_q;

endmodule

>>> rtl/sliding_median_filter.sv
// sliding median filter: window size register, window stage, median, result register
// datapath: the window stage registers the samples; the median is registered in the result register
// throughput: one sample per cycle while the output is not stalled; an end-of-block
//   sample holds the input while the window flushes window_size - 1 - window_size/2
//   repeated samples (up to 3), one median per cycle via the single rank-select unit
// reset: asynchronous, active low; empties both stages, zeroes the window and the
//   block count, window_size returns to 5
module sliding_median_filter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  smf_pkg::in_t          in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output smf_pkg::out_t         out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [smf_pkg::WS_BITS-1:0] cfg_data_i
);
  import smf_pkg::*;

  wsize_t  wsize_q;
  win_t    win;
  stat_t   stat;
  sample_t med;
  logic    adv;
  logic    out_valid_q, out_valid_d;
  out_t    out_q, out_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= WS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      wsize_q <= cfg_data_i;
    end
  end

  // window stage moves on when its result, if any, has room
  assign adv = stat.valid && (!stat.emit || !out_valid_q || out_ready_i);

  smf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .wsize_i    (wsize_q),
    .adv_i      (adv),
    .win_o      (win),
    .stat_o     (stat)
  );

  smf_median u_median (
    .win_i (win),
    .w_i   (stat.w),
    .med_o (med)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (adv && stat.emit) begin
      out_valid_d      = 1'b1;
      out_d.sample_out = stat.pass ? win[0] : med;
      out_d.last_out   = stat.last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> rtl/smf_checker.sv
// port-level checker for the sliding median filter, bound to the top level
`include "sliding_median_filter_defines.svh"

module smf_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input smf_pkg::in_t          in_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input smf_pkg::out_t         out_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [smf_pkg::WS_BITS-1:0] cfg_data_i
);
  import smf_pkg::*;

  wsize_t w_q;
  logic   eob_acc;

  // shadow of the window size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= WS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      w_q <= cfg_data_i;
    end
  end

  assign eob_acc = in_valid_i && in_ready_o && in_i.end_of_block;

  `SMF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_o), "result changed or dropped while stalled")
  `SMF_ASSERT_IMPL(a_ready_fall, $fell(in_ready_o), $past(in_valid_i && in_ready_o), "input stalled without a transaction before")
  `SMF_ASSERT_NEXT(a_flush_busy, eob_acc && int'(clamp_w(w_q)) >= MIN_FILTER, !in_ready_o, "input taken during end-of-block flush")

endmodule

bind sliding_median_filter smf_checker u_smf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_data_i  (cfg_data_i)
);
